FILE: hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character map for the Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam logic [7:0] PAD_CODE    = 8'h3D;
   localparam int         QUEUE_DEPTH = 4;
   localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // one completed group: aligned 24-bit word, byte count (1..3), end of message
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  nbytes;
      logic        last;
   } job_type;

   typedef struct packed {
      logic                empty;
      logic                full;
      logic [QUEUE_AW:0]   count;
   } queue_status_type;

   // 6-bit value of a 7-bit character; anything outside the alphabet gives 0
   function automatic logic [5:0] sextet_of(input logic [6:0] c);
      logic [5:0] v;
      v = 6'd0;
      if (c >= 7'h41 && c <= 7'h5A)      v = 6'(c - 7'h41);
      else if (c >= 7'h61 && c <= 7'h7A) v = 6'(c - 7'h61 + 7'd26);
      else if (c >= 7'h30 && c <= 7'h39) v = 6'(c - 7'h30 + 7'd52);
      else if (c == 7'h2B)               v = 6'd62;
      else if (c == 7'h2F)               v = 6'd63;
      return v;
   endfunction

endpackage

FILE: hw/rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder: characters in, decoded bytes out.
//
//   channel   handshake       payload
//   request   req_push/full   req_char_code[7:0], req_last_char
//   response  rsp_pop/empty   rsp_data_byte[7:0], rsp_run_last, rsp_stream_end
//
// One character is taken per cycle while req_full is low; a completed group
// goes via the job queue to rsp_data_byte, one byte per cycle while popped.
// Byte output is limited by the back end at one byte per cycle, which covers
// the 3-bytes-per-4-characters average; a 4-entry job queue absorbs bursts.
// req_full rises only while the job queue is full; rsp_pop stalls never
// block request acceptance until that queue fills.
// Synchronous reset clears the group state, the queue and the response valid.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);
   import b64d_pkg::*;

   job_type          push_job, head_job;
   logic             job_push, q_pop;
   queue_status_type q_status;

   assign req_full = q_status.full;

   b64d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_full        (q_status.full),
      .job_push      (job_push),
      .job           (push_job)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   b64d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_stream_end) |-> rsp_run_last)
      else $error("stream end without run last");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("job queue over depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !job_push)
      else $error("job pushed into full queue");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("response valid right after reset");

endmodule

FILE: hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, gathers them into groups and posts one job per group.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_char_code,
   input  logic              req_last_char,
   input  logic              q_full,
   output logic              job_push,
   output b64d_pkg::job_type job
);
   import b64d_pkg::*;

   logic [17:0] group_bits_ff, group_bits_in;
   logic [1:0]  char_pos_ff, char_pos_in;
   logic        third_was_pad_ff, third_was_pad_in;

   logic        accept;
   logic        is_pad;
   logic [23:0] acc;
   logic        closes;

   assign accept = req_push && !q_full;
   assign is_pad = (req_char_code == PAD_CODE);
   assign acc    = {group_bits_ff, sextet_of(req_char_code[6:0])};
   assign closes = req_last_char || (char_pos_ff == 2'd3);

   always_comb begin
      group_bits_in    = group_bits_ff;
      char_pos_in      = char_pos_ff;
      third_was_pad_in = third_was_pad_ff;
      job_push         = 1'b0;
      job.last         = req_last_char;
      job.word         = acc;
      job.nbytes       = 2'd1;
      unique case (char_pos_ff)
         2'd0: job.word = {acc[5:0], 18'd0};
         2'd1: job.word = {acc[11:0], 12'd0};
         2'd2: job.word = {acc[17:0], 6'd0};
         2'd3: job.word = acc;
         default: job.word = acc;
      endcase
      unique case (char_pos_ff)
         2'd0, 2'd1: job.nbytes = 2'd1;
         2'd2:       job.nbytes = 2'd2;
         2'd3: begin
            // drop trailing bytes for pads in a final full group
            if (req_last_char) begin
               job.nbytes = 2'd3 - 2'(is_pad) - 2'(third_was_pad_ff);
            end else begin
               job.nbytes = 2'd3;
            end
         end
         default: job.nbytes = 2'd1;
      endcase
      if (accept) begin
         if (closes) begin
            job_push         = 1'b1;
            group_bits_in    = '0;
            char_pos_in      = '0;
            third_was_pad_in = 1'b0;
         end else begin
            group_bits_in = acc[17:0];
            char_pos_in   = char_pos_ff + 2'd1;
            if (char_pos_ff == 2'd2) begin
               third_was_pad_in = is_pad;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_bits_ff    <= '0;
         char_pos_ff      <= '0;
         third_was_pad_ff <= 1'b0;
      end else begin
         group_bits_ff    <= group_bits_in;
         char_pos_ff      <= char_pos_in;
         third_was_pad_ff <= third_was_pad_in;
      end
   end

endmodule

FILE: hw/rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64d_pkg::job_type          push_job,
   input  logic                       pop,
   output b64d_pkg::job_type          head_job,
   output b64d_pkg::queue_status_type status
);
   import b64d_pkg::*;

   job_type             slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Splits queued jobs into bytes for the output register, one per free cycle.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64d_pkg::job_type          head_job,
   input  b64d_pkg::queue_status_type q_status,
   output logic                       q_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [7:0]                 rsp_data_byte,
   output logic                       rsp_run_last,
   output logic                       rsp_stream_end
);
   import b64d_pkg::*;

   logic [1:0] byte_idx_ff, byte_idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       run_last_ff, run_last_in;
   logic       end_ff, end_in;
   logic       out_free;
   logic       is_final;

   assign out_free = !valid_ff || rsp_pop;
   assign is_final = (byte_idx_ff + 2'd1 == head_job.nbytes);

   always_comb begin
      byte_idx_in = byte_idx_ff;
      valid_in    = valid_ff && !rsp_pop;
      data_in     = data_ff;
      run_last_in = run_last_ff;
      end_in      = end_ff;
      q_pop       = 1'b0;
      if (out_free && !q_status.empty) begin
         valid_in    = 1'b1;
         run_last_in = is_final;
         end_in      = is_final && head_job.last;
         unique case (byte_idx_ff)
            2'd0:    data_in = head_job.word[23:16];
            2'd1:    data_in = head_job.word[15:8];
            default: data_in = head_job.word[7:0];
         endcase
         // advance within the job, or retire it on its last byte
         if (is_final) begin
            q_pop       = 1'b1;
            byte_idx_in = '0;
         end else begin
            byte_idx_in = byte_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         byte_idx_ff <= byte_idx_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      run_last_ff <= run_last_in;
      end_ff      <= end_in;
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_stream_end = end_ff;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_decoder: drives Base64 characters into
// the request queue and compares every decoded byte against a local decoder
// model. Covers padding, partial final groups, stray and look-alike pads and
// random stalls on both queue sides.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::PAD_CODE;

   localparam int RANDOM_CHARS = 480;
   localparam int STEADY_CHARS = 60;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PRINT_CAP    = 30;

   typedef struct {
      bit [7:0] data;
      bit       run_last;
      bit       stream_end;
   } byte_result_type;

   class decoder_scoreboard;
      byte_result_type expected_bytes[$];
      bit [17:0]    held_bits;
      bit [1:0]     slot;
      bit           third_pad;
      int           mismatches;
      int           bytes_checked;
      int           chars_seen;
      int           messages_seen;

      task report(string what);
         if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      function bit [5:0] char_value(bit [7:0] code);
         bit [7:0] c;
         bit [7:0] v;
         c = {1'b0, code[6:0]};
         v = 8'd0;
         if (c >= "A" && c <= "Z")      v = c - "A";
         else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
         else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
         else if (c == "+")             v = 8'd62;
         else if (c == "/")             v = 8'd63;
         return v[5:0];
      endfunction

      function void note_request(bit [7:0] code, bit last);
         bit [23:0]       acc;
         bit [23:0]       word;
         int              count;
         byte_result_type r;
         chars_seen++;
         acc = {held_bits, char_value(code)};
         // group still open: hold the sextet and advance
         if (!last && slot != 2'd3) begin
            if (slot == 2'd2)
               third_pad = (code == PAD_CODE);
            held_bits = acc[17:0];
            slot++;
            return;
         end
         word = acc << (6 * (3 - slot));
         case (slot)
            2'd0, 2'd1: count = 1;
            2'd2:       count = 2;
            default: begin
               count = 3;
               // pads only count in the closing group of a message
               if (last && code == PAD_CODE) count--;
               if (last && third_pad) count--;
            end
         endcase
         for (int k = 0; k < count; k++) begin
            r.data       = word[23 - 8 * k -: 8];
            r.run_last   = (k == count - 1);
            r.stream_end = last && (k == count - 1);
            expected_bytes.push_back(r);
         end
         if (last) messages_seen++;
         held_bits = '0;
         slot      = '0;
         third_pad = 1'b0;
      endfunction

      task check_byte(bit [7:0] data, bit run_last, bit stream_end);
         byte_result_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("byte %02h arrived with nothing expected", data));
            return;
         end
         want = expected_bytes.pop_front();
         bytes_checked++;
         if (data !== want.data)
            report($sformatf("data_byte got %02h want %02h", data, want.data));
         if (run_last !== want.run_last)
            report($sformatf("run_last got %b want %b (byte %02h)",
                             run_last, want.run_last, want.data));
         if (stream_end !== want.stream_end)
            report($sformatf("stream_end got %b want %b (byte %02h)",
                             stream_end, want.stream_end, want.data));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_char_code;
   logic       req_last_char;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_data_byte;
   logic       rsp_run_last;
   logic       rsp_stream_end;

   decoder_scoreboard sb = new();
   string base64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   bit    steady = 1'b0;
   bit    calm   = 1'b0;
   int    cycles = 0;

   base64_stream_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_byte(rsp_data_byte, rsp_run_last, rsp_stream_end);
   end

   // response side: pop with random stall bursts
   initial begin
      rsp_pop <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task send_request(bit [7:0] code, bit last);
      if (!steady && !calm && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_char_code <= code;
      req_last_char <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_request(code, last);
   endtask

   task send_string(string s, bit ends);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], ends && (i == s.len() - 1));
   endtask

   task wait_drained();
      while (sb.expected_bytes.size() != 0) @(posedge clock);
   endtask

   task send_random_message();
      bit [7:0] msg [0:39];
      int       len;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            msg[i] = 8'($urandom_range(0, 255));
         else
            msg[i] = base64_chars[$urandom_range(0, 63)]
                     | (($urandom_range(0, 11) == 0) ? 8'h80 : 8'h00);
      end
      // shape the closing group: real pads, a lone third pad, a pad look-alike
      if (len % 4 == 0) begin
         case ($urandom_range(0, 5))
            1: msg[len - 1] = PAD_CODE;
            2: begin
               msg[len - 2] = PAD_CODE;
               msg[len - 1] = PAD_CODE;
            end
            3: msg[len - 2] = PAD_CODE;
            4: msg[len - 1] = 8'hBD;
            default: ;
         endcase
      end
      if ($urandom_range(0, 7) == 0)
         msg[$urandom_range(0, len - 1)] = PAD_CODE;
      for (int i = 0; i < len; i++)
         send_request(msg[i], i == len - 1);
   endtask

   initial begin
      int  random_start;
      bit  paused;
      paused = 1'b0;
      reset         <= 1'b1;
      req_push      <= 1'b0;
      req_char_code <= 8'h00;
      req_last_char <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_string("TWFu", 1'b1);
      send_string("TWE=", 1'b1);
      send_string("TQ==", 1'b1);
      send_string("z9=\275", 1'b1);
      send_string("=\301", 1'b0);
      send_request(8'h00, 1'b0);
      send_string("a", 1'b0);
      send_string("\377", 1'b1);
      send_string("/+", 1'b1);
      send_string("+/9", 1'b1);

      random_start = sb.chars_seen;
      while (sb.chars_seen - random_start < RANDOM_CHARS) begin
         steady = (sb.chars_seen - random_start >= RANDOM_CHARS - STEADY_CHARS);
         // once mid-run, hold requests until every byte is out
         if (!paused && sb.chars_seen - random_start >= RANDOM_CHARS / 2) begin
            req_push <= 1'b0;
            wait_drained();
            paused = 1'b1;
         end
         send_random_message();
      end
      req_push <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d characters in %0d messages decoded, %0d bytes compared",
               sb.chars_seen, sb.messages_seen, sb.bytes_checked);
      $display("stalls on both sides, pads, partial groups; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: base64_stream_decoder.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
tb/tb.sv
